// ===== rtl/core/tkmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tkmh_pkg
// Shared widths, datapath op codes and status struct for the top-k selector.
// ----------------------------------------------------------------------------
package tkmh_pkg;

    localparam int HEAP_SIZE = 20;
    localparam int DOC_W     = 20;
    localparam int SCORE_W   = 16;
    localparam int RANK_W    = 7;
    // heap slots are numbered 1..HEAP_SIZE, slot 0 unused
    localparam int SLOT_W    = $clog2(HEAP_SIZE + 1);
    localparam int OP_W      = 4;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_NOP       = 4'd0;
    localparam op_t OP_ACCEPT    = 4'd1;
    localparam op_t OP_READ_TOP  = 4'd2;
    localparam op_t OP_REPLY     = 4'd3;
    localparam op_t OP_POP       = 4'd4;
    localparam op_t OP_TAKE_LAST = 4'd5;
    localparam op_t OP_SD_ISSUE  = 4'd6;
    localparam op_t OP_SD_EVAL   = 4'd7;
    localparam op_t OP_INSERT    = 4'd8;
    localparam op_t OP_SU_ISSUE  = 4'd9;
    localparam op_t OP_SU_EVAL   = 4'd10;
    localparam op_t OP_REFILL    = 4'd11;

    typedef struct packed {
        logic better;
        logic sd_has_child;
        logic sd_move;
        logic sd_more;
        logic su_has_parent;
        logic su_move;
        logic su_more;
        logic cnt_zero;
    } dp_status_t;

endpackage

// ===== rtl/core/tkmh_datapath.sv =====
// ----------------------------------------------------------------------------
// tkmh_datapath
// Heap memory with two registered read ports, sift compare logic, entry
// count, held entry and result registers.
// ----------------------------------------------------------------------------
module tkmh_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tkmh_pkg::op_t                 op,
    input  logic [tkmh_pkg::DOC_W-1:0]    doc_id,
    input  logic [tkmh_pkg::SCORE_W-1:0]  score,
    output tkmh_pkg::dp_status_t          status,
    output logic                          strobe,
    output logic [tkmh_pkg::DOC_W-1:0]    out_doc,
    output logic [tkmh_pkg::SCORE_W-1:0]  out_score,
    output logic [tkmh_pkg::RANK_W-1:0]   rank,
    output logic                          last
);

    localparam logic [tkmh_pkg::SLOT_W-1:0] SLOT_ONE  = tkmh_pkg::SLOT_W'(1);
    localparam logic [tkmh_pkg::SLOT_W-1:0] SLOT_FULL = tkmh_pkg::SLOT_W'(tkmh_pkg::HEAP_SIZE);

    logic [tkmh_pkg::DOC_W-1:0]   mem_doc   [0:tkmh_pkg::HEAP_SIZE];
    logic [tkmh_pkg::SCORE_W-1:0] mem_score [0:tkmh_pkg::HEAP_SIZE];
    logic [tkmh_pkg::HEAP_SIZE:0] valid_reg;

    logic                         rd_en;
    logic [tkmh_pkg::SLOT_W-1:0]  rda_addr;
    logic [tkmh_pkg::SLOT_W-1:0]  rdb_addr;
    logic [tkmh_pkg::DOC_W-1:0]   rda_doc_reg;
    logic [tkmh_pkg::SCORE_W-1:0] rda_score_reg;
    logic                         rda_vld_reg;
    logic [tkmh_pkg::DOC_W-1:0]   rdb_doc_reg;
    logic [tkmh_pkg::SCORE_W-1:0] rdb_score_reg;
    logic                         rdb_vld_reg;

    logic                         wr_en;
    logic [tkmh_pkg::SLOT_W-1:0]  wr_addr;
    logic [tkmh_pkg::DOC_W-1:0]   wr_doc;
    logic [tkmh_pkg::SCORE_W-1:0] wr_score;
    logic                         refill;

    logic [tkmh_pkg::SLOT_W-1:0]  cnt_reg,  cnt_next;
    logic [tkmh_pkg::SLOT_W-1:0]  pos_reg,  pos_next;
    logic [tkmh_pkg::DOC_W-1:0]   hold_doc_reg,   hold_doc_next;
    logic [tkmh_pkg::SCORE_W-1:0] hold_score_reg, hold_score_next;
    logic [tkmh_pkg::DOC_W-1:0]   cand_doc_reg,   cand_doc_next;
    logic [tkmh_pkg::SCORE_W-1:0] cand_score_reg, cand_score_next;
    logic                         strobe_reg, strobe_next;
    logic [tkmh_pkg::DOC_W-1:0]   out_doc_reg,   out_doc_next;
    logic [tkmh_pkg::SCORE_W-1:0] out_score_reg, out_score_next;
    logic [tkmh_pkg::RANK_W-1:0]  rank_reg,  rank_next;
    logic                         last_reg,  last_next;

    // never-written slots read as zero
    logic [tkmh_pkg::DOC_W-1:0]   a_doc, b_doc;
    logic [tkmh_pkg::SCORE_W-1:0] a_score, b_score;

    logic [tkmh_pkg::SLOT_W:0]    c_full, c2_full, cnt_ext;
    logic [tkmh_pkg::SLOT_W-1:0]  c_addr, c1_addr, c2_addr, c2p1_addr;
    logic                         pick_right;
    logic [tkmh_pkg::SLOT_W-1:0]  child_idx;
    logic [tkmh_pkg::DOC_W-1:0]   child_doc;
    logic [tkmh_pkg::SCORE_W-1:0] child_score;
    logic [tkmh_pkg::SLOT_W-1:0]  par_addr, gpar_addr;

    assign a_doc   = rda_vld_reg ? rda_doc_reg   : '0;
    assign a_score = rda_vld_reg ? rda_score_reg : '0;
    assign b_doc   = rdb_vld_reg ? rdb_doc_reg   : '0;
    assign b_score = rdb_vld_reg ? rdb_score_reg : '0;

    // sift-down: children of pos, read in the previous cycle
    assign cnt_ext     = {1'b0, cnt_reg};
    assign c_full      = {pos_reg, 1'b0};
    assign c_addr      = c_full[tkmh_pkg::SLOT_W-1:0];
    assign c1_addr     = c_addr + SLOT_ONE;
    assign pick_right  = (c_full < cnt_ext) && (a_score > b_score);
    assign child_idx   = pick_right ? c1_addr : c_addr;
    assign child_doc   = pick_right ? b_doc   : a_doc;
    assign child_score = pick_right ? b_score : a_score;
    assign c2_full     = {child_idx, 1'b0};
    assign c2_addr     = c2_full[tkmh_pkg::SLOT_W-1:0];
    assign c2p1_addr   = c2_addr + SLOT_ONE;

    // sift-up: parent of pos in port a
    assign par_addr  = pos_reg >> 1;
    assign gpar_addr = par_addr >> 1;

    always_comb
    begin
        status.better        = cand_score_reg > a_score;
        status.sd_has_child  = c_full <= cnt_ext;
        status.sd_move       = child_score < hold_score_reg;
        status.sd_more       = c2_full <= cnt_ext;
        status.su_has_parent = par_addr != '0;
        status.su_move       = a_score > hold_score_reg;
        status.su_more       = gpar_addr != '0;
        status.cnt_zero      = cnt_reg == '0;
    end

    always_comb
    begin
        rd_en           = 1'b0;
        rda_addr        = c_addr;
        rdb_addr        = c1_addr;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_doc          = hold_doc_reg;
        wr_score        = hold_score_reg;
        refill          = 1'b0;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        hold_doc_next   = hold_doc_reg;
        hold_score_next = hold_score_reg;
        cand_doc_next   = cand_doc_reg;
        cand_score_next = cand_score_reg;
        strobe_next     = 1'b0;
        out_doc_next    = out_doc_reg;
        out_score_next  = out_score_reg;
        rank_next       = rank_reg;
        last_next       = last_reg;
        case (op)
            tkmh_pkg::OP_ACCEPT:
            begin
                cand_doc_next   = doc_id;
                cand_score_next = score;
                rd_en           = 1'b1;
                rda_addr        = SLOT_ONE;
                rdb_addr        = cnt_reg;
            end
            tkmh_pkg::OP_READ_TOP:
            begin
                rd_en    = 1'b1;
                rda_addr = SLOT_ONE;
                rdb_addr = cnt_reg;
            end
            tkmh_pkg::OP_REPLY:
            begin
                strobe_next    = 1'b1;
                out_doc_next   = a_doc;
                out_score_next = a_score;
                rank_next      = '0;
                last_next      = 1'b1;
            end
            tkmh_pkg::OP_POP:
            begin
                strobe_next     = 1'b1;
                out_doc_next    = a_doc;
                out_score_next  = a_score;
                rank_next       = tkmh_pkg::RANK_W'(cnt_reg);
                last_next       = cnt_reg == SLOT_ONE;
                hold_doc_next   = b_doc;
                hold_score_next = b_score;
                cnt_next        = cnt_reg - SLOT_ONE;
                pos_next        = SLOT_ONE;
            end
            tkmh_pkg::OP_TAKE_LAST:
            begin
                hold_doc_next   = b_doc;
                hold_score_next = b_score;
                cnt_next        = cnt_reg - SLOT_ONE;
                pos_next        = SLOT_ONE;
            end
            tkmh_pkg::OP_SD_ISSUE:
            begin
                if (status.sd_has_child)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            tkmh_pkg::OP_SD_EVAL:
            begin
                wr_en = 1'b1;
                if (status.sd_move)
                begin
                    wr_doc   = child_doc;
                    wr_score = child_score;
                    pos_next = child_idx;
                    if (status.sd_more)
                    begin
                        rd_en    = 1'b1;
                        rda_addr = c2_addr;
                        rdb_addr = c2p1_addr;
                    end
                end
            end
            tkmh_pkg::OP_INSERT:
            begin
                cnt_next        = cnt_reg + SLOT_ONE;
                pos_next        = cnt_reg + SLOT_ONE;
                hold_doc_next   = cand_doc_reg;
                hold_score_next = cand_score_reg;
            end
            tkmh_pkg::OP_SU_ISSUE:
            begin
                if (status.su_has_parent)
                begin
                    rd_en    = 1'b1;
                    rda_addr = par_addr;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            tkmh_pkg::OP_SU_EVAL:
            begin
                wr_en = 1'b1;
                if (status.su_move)
                begin
                    wr_doc   = a_doc;
                    wr_score = a_score;
                    pos_next = par_addr;
                    if (status.su_more)
                    begin
                        rd_en    = 1'b1;
                        rda_addr = gpar_addr;
                    end
                end
            end
            tkmh_pkg::OP_REFILL:
            begin
                refill   = 1'b1;
                cnt_next = SLOT_FULL;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // heap storage, one write and two registered reads per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_doc[wr_addr]   <= wr_doc;
            mem_score[wr_addr] <= wr_score;
        end
        if (rd_en)
        begin
            rda_doc_reg   <= mem_doc[rda_addr];
            rda_score_reg <= mem_score[rda_addr];
            rda_vld_reg   <= valid_reg[rda_addr];
            rdb_doc_reg   <= mem_doc[rdb_addr];
            rdb_score_reg <= mem_score[rdb_addr];
            rdb_vld_reg   <= valid_reg[rdb_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            cnt_reg    <= SLOT_FULL;
            strobe_reg <= 1'b0;
        end
        else
        begin
            if (refill)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        hold_doc_reg   <= hold_doc_next;
        hold_score_reg <= hold_score_next;
        cand_doc_reg   <= cand_doc_next;
        cand_score_reg <= cand_score_next;
        out_doc_reg    <= out_doc_next;
        out_score_reg  <= out_score_next;
        rank_reg       <= rank_next;
        last_reg       <= last_next;
    end

    assign strobe    = strobe_reg;
    assign out_doc   = out_doc_reg;
    assign out_score = out_score_reg;
    assign rank      = rank_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/core/tkmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// tkmh_ctrl
// Sequencer for offer and drain: steps the datapath through pop, sift-down,
// insert, sift-up, result and refill.
// ----------------------------------------------------------------------------
module tkmh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cmd,
    input  tkmh_pkg::dp_status_t status,
    output tkmh_pkg::op_t        op,
    output logic                 busy
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CMP       = 4'd1;
    localparam logic [3:0] S_SD_ISSUE  = 4'd2;
    localparam logic [3:0] S_SD_EVAL   = 4'd3;
    localparam logic [3:0] S_INSERT    = 4'd4;
    localparam logic [3:0] S_SU_ISSUE  = 4'd5;
    localparam logic [3:0] S_SU_EVAL   = 4'd6;
    localparam logic [3:0] S_RD_TOP    = 4'd7;
    localparam logic [3:0] S_REPLY     = 4'd8;
    localparam logic [3:0] S_DRN_RD    = 4'd9;
    localparam logic [3:0] S_POP       = 4'd10;
    localparam logic [3:0] S_REFILL    = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       drain_reg, drain_next;
    logic [3:0] sd_done_state;

    // where to go once the moved entry has settled
    always_comb
    begin
        if (!drain_reg)
        begin
            sd_done_state = S_INSERT;
        end
        else if (status.cnt_zero)
        begin
            sd_done_state = S_REFILL;
        end
        else
        begin
            sd_done_state = S_DRN_RD;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        op         = tkmh_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = tkmh_pkg::OP_ACCEPT;
                    drain_next = cmd;
                    state_next = cmd ? S_POP : S_CMP;
                end
            end
            S_CMP:
            begin
                if (status.better)
                begin
                    op         = tkmh_pkg::OP_TAKE_LAST;
                    state_next = S_SD_ISSUE;
                end
                else
                begin
                    op         = tkmh_pkg::OP_REPLY;
                    state_next = S_IDLE;
                end
            end
            S_SD_ISSUE:
            begin
                op         = tkmh_pkg::OP_SD_ISSUE;
                state_next = status.sd_has_child ? S_SD_EVAL : sd_done_state;
            end
            S_SD_EVAL:
            begin
                op = tkmh_pkg::OP_SD_EVAL;
                if (!status.sd_move)
                begin
                    state_next = sd_done_state;
                end
                else if (!status.sd_more)
                begin
                    state_next = S_SD_ISSUE;
                end
            end
            S_INSERT:
            begin
                op         = tkmh_pkg::OP_INSERT;
                state_next = S_SU_ISSUE;
            end
            S_SU_ISSUE:
            begin
                op         = tkmh_pkg::OP_SU_ISSUE;
                state_next = status.su_has_parent ? S_SU_EVAL : S_RD_TOP;
            end
            S_SU_EVAL:
            begin
                op = tkmh_pkg::OP_SU_EVAL;
                if (!status.su_move)
                begin
                    state_next = S_RD_TOP;
                end
                else if (!status.su_more)
                begin
                    state_next = S_SU_ISSUE;
                end
            end
            S_RD_TOP:
            begin
                op         = tkmh_pkg::OP_READ_TOP;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                op         = tkmh_pkg::OP_REPLY;
                state_next = S_IDLE;
            end
            S_DRN_RD:
            begin
                op         = tkmh_pkg::OP_READ_TOP;
                state_next = S_POP;
            end
            S_POP:
            begin
                op         = tkmh_pkg::OP_POP;
                state_next = S_SD_ISSUE;
            end
            S_REFILL:
            begin
                op         = tkmh_pkg::OP_REFILL;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

// ===== rtl/core/top_k_min_heap_selector.sv =====
// ----------------------------------------------------------------------------
// top_k_min_heap_selector
// Keeps the HEAP_SIZE best (doc, score) pairs in an array min-heap; offers
// replace the minimum when strictly better, drains emit all entries in
// ascending score order and then refill the heap with zero entries.
// ----------------------------------------------------------------------------
//
//  channel  | handshake         | word
//  ---------+-------------------+--------------------------------------
//  command  | start, busy       | cmd, doc_id, score
//  result   | strobe            | out_doc, out_score, rank, last
//
// a word is taken at a clock edge with start high and busy low
// offer that does not beat the minimum: the root is read, compared and replied
// offer that replaces the minimum: the last entry moves to the root and sifts
// down, the offer goes in at the end and sifts up, each sift bounded by
// log2(HEAP_SIZE) levels; one heap level per cycle is set by the single write
// port of the heap memory; drain: HEAP_SIZE results, each popped from the root
// and followed by a sift-down, then a refill; reset and refill leave the heap full of zero entries
// results are shown for one cycle on strobe and cannot be held off
//
module top_k_min_heap_selector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [tkmh_pkg::DOC_W-1:0]    doc_id,
    input  logic [tkmh_pkg::SCORE_W-1:0]  score,
    output logic                          strobe,
    output logic [tkmh_pkg::DOC_W-1:0]    out_doc,
    output logic [tkmh_pkg::SCORE_W-1:0]  out_score,
    output logic [tkmh_pkg::RANK_W-1:0]   rank,
    output logic                          last
);

    tkmh_pkg::op_t        op;
    tkmh_pkg::dp_status_t status;

    tkmh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .op     (op),
        .busy   (busy)
    );

    tkmh_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .doc_id    (doc_id),
        .score     (score),
        .status    (status),
        .strobe    (strobe),
        .out_doc   (out_doc),
        .out_score (out_score),
        .rank      (rank),
        .last      (last)
    );

endmodule

// ===== rtl/core/tkmh_checker.sv =====
// ----------------------------------------------------------------------------
// tkmh_checker
// Port-level checks on command acceptance and result marking.
// ----------------------------------------------------------------------------
module tkmh_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         strobe,
    input logic [tkmh_pkg::RANK_W-1:0]  rank,
    input logic                         last
);

    localparam logic [tkmh_pkg::RANK_W-1:0] RANK_ONE = tkmh_pkg::RANK_W'(1);

    // an accepted word keeps the block busy for at least the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not make the block busy");

    // no result can appear in the cycle right after acceptance
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !strobe)
        else $error("result appeared right after acceptance");

    // last marks offer replies and the best drained entry only
    a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == (rank == '0 || rank == RANK_ONE)))
        else $error("last flag does not match rank");

    // a drain result that is not the final one leaves work pending
    a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("drain stopped before the final result");

endmodule

bind top_k_min_heap_selector tkmh_checker u_tkmh_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .rank   (rank),
    .last   (last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives offer and drain words into the top-k heap selector from a queue,
// predicts every reply and drained entry with a behavioral heap of its own,
// and checks each strobed result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic CMD_OFFER     = 1'b0;
    localparam logic CMD_DRAIN     = 1'b1;
    localparam int   NUM_RANDOM    = 400;
    localparam int   STALL_LIMIT   = 4000;
    localparam int   SETTLE_CYCLES = 16;
    localparam int   MAX_REPORTS   = 10;

    typedef struct {
        logic                         op;
        logic [tkmh_pkg::DOC_W-1:0]   doc;
        logic [tkmh_pkg::SCORE_W-1:0] sc;
        bit                           sync_first;
    } cmd_word_t;

    typedef struct {
        logic [tkmh_pkg::DOC_W-1:0]   doc;
        logic [tkmh_pkg::SCORE_W-1:0] sc;
        logic [tkmh_pkg::RANK_W-1:0]  rnk;
        logic                         fin;
    } ranked_entry_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         cmd = CMD_OFFER;
    logic [tkmh_pkg::DOC_W-1:0]   doc_id = '0;
    logic [tkmh_pkg::SCORE_W-1:0] score = '0;
    logic                         strobe;
    logic [tkmh_pkg::DOC_W-1:0]   out_doc;
    logic [tkmh_pkg::SCORE_W-1:0] out_score;
    logic [tkmh_pkg::RANK_W-1:0]  rank;
    logic                         last;

    cmd_word_t     pending_words[$];
    ranked_entry_t expected_entries[$];

    // behavioral heap, slots 1..HEAP_SIZE
    logic [tkmh_pkg::DOC_W-1:0]   kept_doc   [1:tkmh_pkg::HEAP_SIZE];
    logic [tkmh_pkg::SCORE_W-1:0] kept_score [1:tkmh_pkg::HEAP_SIZE];
    int                           kept_count;

    logic word_taken = 1'b0;
    int   words_sent = 0;
    int   stall_count = 0;
    int   n_mismatch = 0;
    int   n_offers = 0;
    int   n_replaced = 0;
    int   n_drains = 0;
    int   n_checked = 0;

    top_k_min_heap_selector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .doc_id    (doc_id),
        .score     (score),
        .strobe    (strobe),
        .out_doc   (out_doc),
        .out_score (out_score),
        .rank      (rank),
        .last      (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void heap_clear();
        for (int i = 1; i <= tkmh_pkg::HEAP_SIZE; i++)
        begin
            kept_doc[i]   = '0;
            kept_score[i] = '0;
        end
        kept_count = tkmh_pkg::HEAP_SIZE;
    endfunction

    // last entry to the root, then sift down with strict compares
    function automatic void heap_take_root();
        int                           pos;
        int                           c;
        logic [tkmh_pkg::DOC_W-1:0]   d;
        logic [tkmh_pkg::SCORE_W-1:0] s;
        if (kept_count == 0)
            return;
        kept_score[1] = kept_score[kept_count];
        kept_doc[1]   = kept_doc[kept_count];
        kept_count--;
        if (kept_count == 0)
            return;
        pos = 1;
        s   = kept_score[1];
        d   = kept_doc[1];
        c   = 2;
        while (c <= kept_count)
        begin
            if (c < kept_count && kept_score[c] > kept_score[c + 1])
                c++;
            if (kept_score[c] < s)
            begin
                kept_score[pos] = kept_score[c];
                kept_doc[pos]   = kept_doc[c];
                pos = c;
                c   = c * 2;
            end
            else
                break;
        end
        kept_score[pos] = s;
        kept_doc[pos]   = d;
    endfunction

    function automatic void queue_word(logic op, logic [tkmh_pkg::DOC_W-1:0] doc,
                                       logic [tkmh_pkg::SCORE_W-1:0] sc, bit sync_first);
        cmd_word_t w;
        w.op         = op;
        w.doc        = doc;
        w.sc         = sc;
        w.sync_first = sync_first;
        pending_words.push_back(w);
    endfunction

    // driver: a word is held until taken, next one chosen at the falling edge
    always @(negedge clk)
    begin : drive_words
        cmd_word_t w;
        bit        go;
        bit        quiet_stretch;
        if (!rst_n)
            start <= 1'b0;
        else if (!start || word_taken)
        begin
            go = 1'b0;
            quiet_stretch = (words_sent >= 150 && words_sent < 260);
            if (pending_words.size() != 0)
            begin
                if (pending_words[0].sync_first && expected_entries.size() != 0)
                    go = 1'b0;
                else if (!quiet_stretch && $urandom_range(99) < 22)
                    go = 1'b0;
                else
                    go = 1'b1;
            end
            if (go)
            begin
                w = pending_words.pop_front();
                cmd    <= w.op;
                doc_id <= w.doc;
                score  <= w.sc;
                start  <= 1'b1;
                words_sent++;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check strobed results, then predict the word taken at this edge
    always @(posedge clk)
    begin : check_and_predict
        ranked_entry_t                exp_e;
        ranked_entry_t                new_e;
        int                           pos;
        int                           p;
        logic [tkmh_pkg::DOC_W-1:0]   d;
        logic [tkmh_pkg::SCORE_W-1:0] s;
        if (strobe)
        begin
            if (expected_entries.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: unexpected result doc=%0h score=%0h rank=%0d last=%0b",
                             $realtime, out_doc, out_score, rank, last);
            end
            else
            begin
                exp_e = expected_entries.pop_front();
                n_checked++;
                if (out_doc !== exp_e.doc || out_score !== exp_e.sc ||
                    rank !== exp_e.rnk || last !== exp_e.fin)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: mismatch exp doc=%0h score=%0h rank=%0d last=%0b, %s",
                                 $realtime, exp_e.doc, exp_e.sc, exp_e.rnk, exp_e.fin,
                                 $sformatf("got doc=%0h score=%0h rank=%0d last=%0b",
                                           out_doc, out_score, rank, last));
                end
            end
        end

        word_taken <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            if (cmd == CMD_OFFER)
            begin
                n_offers++;
                if (kept_count == tkmh_pkg::HEAP_SIZE && score > kept_score[1])
                begin
                    n_replaced++;
                    heap_take_root();
                    kept_count++;
                    pos = kept_count;
                    kept_doc[pos]   = doc_id;
                    kept_score[pos] = score;
                    s = score;
                    d = doc_id;
                    p = pos / 2;
                    while (p >= 1)
                    begin
                        if (kept_score[p] > s)
                        begin
                            kept_score[pos] = kept_score[p];
                            kept_doc[pos]   = kept_doc[p];
                            pos = p;
                            p   = p / 2;
                        end
                        else
                            break;
                    end
                    kept_score[pos] = s;
                    kept_doc[pos]   = d;
                end
                new_e.doc = kept_doc[1];
                new_e.sc  = kept_score[1];
                new_e.rnk = '0;
                new_e.fin = 1'b1;
                expected_entries.push_back(new_e);
            end
            else
            begin
                n_drains++;
                for (int r = tkmh_pkg::HEAP_SIZE; r >= 1; r--)
                begin
                    new_e.doc = kept_doc[1];
                    new_e.sc  = kept_score[1];
                    new_e.rnk = r[tkmh_pkg::RANK_W-1:0];
                    new_e.fin = (r == 1);
                    expected_entries.push_back(new_e);
                    heap_take_root();
                end
                heap_clear();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            stall_count <= 0;
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int sel;
        int kind;
        logic [tkmh_pkg::SCORE_W-1:0] sc;

        heap_clear();

        // directed: equal-to-root offer, extremes, ties, a drain of a zero heap
        queue_word(CMD_OFFER, 20'hFFFFF, 16'h0000, 1'b0);
        queue_word(CMD_OFFER, 20'h00000, 16'h0001, 1'b0);
        queue_word(CMD_OFFER, 20'hFFFFF, 16'hFFFF, 1'b0);
        queue_word(CMD_OFFER, 20'h00001, 16'h0001, 1'b0);
        queue_word(CMD_OFFER, 20'h00064, 16'h0064, 1'b0);
        queue_word(CMD_OFFER, 20'h00065, 16'h0064, 1'b0);
        queue_word(CMD_OFFER, 20'h00066, 16'h0064, 1'b0);
        queue_word(CMD_OFFER, 20'h12345, 16'hFFFF, 1'b0);
        queue_word(CMD_OFFER, 20'hAAAAA, 16'h5555, 1'b0);
        queue_word(CMD_OFFER, 20'h55555, 16'hAAAA, 1'b0);
        queue_word(CMD_DRAIN, 20'hFFFFF, 16'hFFFF, 1'b0);
        queue_word(CMD_OFFER, 20'h0BEEF, 16'h0000, 1'b0);
        queue_word(CMD_DRAIN, 20'h00000, 16'h0000, 1'b0);
        for (int i = 0; i < 22; i++)
            queue_word(CMD_OFFER, 20'(i + 1), 16'(100 - i), 1'b0);
        queue_word(CMD_OFFER, 20'h77777, 16'h0050, 1'b0);
        queue_word(CMD_DRAIN, 20'h00000, 16'h0000, 1'b1);

        // random: mostly offers, a drain now and then, pauses until idle
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                queue_word(CMD_DRAIN, 20'($urandom), 16'($urandom), 1'b0);
            else
            begin
                kind = $urandom_range(3);
                case (kind)
                    0:       sc = 16'($urandom_range(15));
                    1:       sc = 16'($urandom_range(65535, 65520));
                    default: sc = 16'($urandom);
                endcase
                queue_word(CMD_OFFER, 20'($urandom), sc,
                           (i == NUM_RANDOM / 2) || ($urandom_range(49) == 0));
            end
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_entries.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d offers (%0d took the minimum's place) and %0d drains",
                 n_offers, n_replaced, n_drains);
        $display("%0d results checked, %0d mismatches", n_checked, n_mismatch);
        if (n_mismatch == 0 && expected_entries.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
